// File: design/mslfc_pkg.sv
// Shared types, constants and helper functions for the mood slew limiter
// and face classifier. No dependencies; imported by every module of the block.
package mslfc_pkg;

	// Time arithmetic wraps at 2^TIME_BITS
	localparam int TIME_BITS = 32;
	localparam int NOW_W     = 32;
	localparam int PROD_W    = 32;

	// Stream and config port widths
	localparam int S_DATA_W  = 72;
	localparam int M_DATA_W  = 48;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 32;

	// Register indexes on the config channel
	localparam logic [CFG_IDX_W-1:0] REG_BASE_VALENCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_AROUSAL = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_ENERGY  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MS   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_MS    = 3'd4;

	// Config reset values
	localparam logic [31:0] TIMEOUT_RST = 32'd3000;
	localparam logic [15:0] SMOOTH_RST  = 16'd400;

	// Mood range
	localparam logic signed [7:0] MOOD_MAX = 8'sd100;
	localparam logic signed [7:0] MOOD_MIN = -8'sd100;

	// Drift step dt/100: capped at the largest useful step, reciprocal below it
	localparam logic [31:0] DRIFT_DT_CAP = 32'd20000;
	localparam logic [7:0]  STEP_CAP     = 8'd200;
	localparam int          RECIP_SHIFT  = 19;
	localparam logic [27:0] RECIP_100    = 28'd5243;
	localparam logic [31:0] SLEW_SCALE   = 32'd100;

	// Slew step divider: quotient bits resolved one per cycle
	localparam int QUO_W = 8;

	// Blink period
	localparam logic signed [13:0] BLINK_BASE = 14'sd4200;
	localparam logic signed [13:0] BLINK_MIN  = 14'sd1800;

	// Face classes
	localparam logic [3:0] FACE_SLEEPING = 4'd0;
	localparam logic [3:0] FACE_SLEEPY   = 4'd1;
	localparam logic [3:0] FACE_EXCITED  = 4'd2;
	localparam logic [3:0] FACE_HAPPY    = 4'd3;
	localparam logic [3:0] FACE_PROUD    = 4'd4;
	localparam logic [3:0] FACE_SAD      = 4'd5;
	localparam logic [3:0] FACE_CONFUSED = 4'd6;
	localparam logic [3:0] FACE_BORED    = 4'd7;
	localparam logic [3:0] FACE_IDLE     = 4'd8;

	typedef logic signed [7:0] mood_t;
	typedef logic [TIME_BITS-1:0] time_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic capture;
		logic eval;
		logic set_apply;
		logic start;
		logic mul;
		logic advance;
		logic pre;
		logic div_step;
		logic slew;
		logic load_out;
	} mslfc_cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic mode;
		logic started;
		logic dt_zero;
		logic out_free;
	} mslfc_sts_t;

	// Saturate to the mood range
	function automatic mood_t sat100(input mood_t v);
		mood_t r;
		if (v < MOOD_MIN) begin
			r = MOOD_MIN;
		end else if (v > MOOD_MAX) begin
			r = MOOD_MAX;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// Move cur toward tgt by at most step, no overshoot
	function automatic mood_t move_toward(input mood_t cur, input mood_t tgt,
			input logic [7:0] step);
		logic signed [9:0] d;
		logic signed [9:0] s;
		logic signed [9:0] c;
		logic signed [9:0] sum;
		mood_t r;
		c = {{2{cur[7]}}, cur};
		d = {{2{tgt[7]}}, tgt} - c;
		s = {2'b00, step};
		if (d > s) begin
			sum = c + s;
			r = sum[7:0];
		end else if (d < -s) begin
			sum = c - s;
			r = sum[7:0];
		end else begin
			r = tgt;
		end
		return r;
	endfunction

endpackage

// File: design/mslfc_ctrl.sv
// Sequencer for the mood slew limiter: walks each item through evaluate and, for a
// tick that moves time, multiply, divide and slew steps. Depends on mslfc_pkg.
module mslfc_ctrl import mslfc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  mslfc_sts_t sts,
	output mslfc_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EVAL = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_PRE  = 3'd3;
	localparam logic [2:0] ST_DIV  = 3'd4;
	localparam logic [2:0] ST_SLEW = 3'd5;
	localparam logic [2:0] ST_OUT  = 3'd6;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic [2:0] cnt_q;

	assign s_tready = (state_q == ST_IDLE);

	// Decode state into commands and next state
	always_comb begin
		cmd = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (sts.mode) begin
					cmd.set_apply = 1'b1;
					state_nxt = ST_OUT;
				end else if (!sts.started) begin
					cmd.start = 1'b1;
					state_nxt = ST_OUT;
				end else begin
					state_nxt = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				if (sts.dt_zero) begin
					state_nxt = ST_OUT;
				end else begin
					cmd.advance = 1'b1;
					state_nxt = ST_PRE;
				end
			end
			ST_PRE: begin
				cmd.pre = 1'b1;
				state_nxt = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == '0) begin
					state_nxt = ST_SLEW;
				end
			end
			ST_SLEW: begin
				cmd.slew = 1'b1;
				state_nxt = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// Advance state; count divider iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
		end else begin
			state_q <= state_nxt;
			if (cmd.pre) begin
				cnt_q <= 3'(QUO_W - 1);
			end else if (cmd.div_step) begin
				cnt_q <= cnt_q - 3'd1;
			end
		end
	end

endmodule

// File: design/mslfc_dpath.sv
// Datapath for the mood slew limiter: config registers, mood state, time
// arithmetic, step divider, face ladder and output register. Depends on mslfc_pkg.
module mslfc_dpath import mslfc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [S_DATA_W-1:0]  s_tdata,
	input  logic [0:0]           s_tuser,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data,
	input  mslfc_cmd_t           cmd,
	output mslfc_sts_t           sts,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata
);

	// Config registers
	mood_t       base_v_q, base_a_q, base_e_q;
	logic [31:0] timeout_q;
	logic [15:0] smooth_q;

	// Mood state
	mood_t cur_v_q, cur_a_q, cur_e_q;
	mood_t tgt_v_q, tgt_a_q, tgt_e_q;
	time_t last_tick_q, last_upd_q;

	// Captured item
	logic        mode_q;
	time_t       now_q;
	mood_t       new_v_q, new_a_q, new_e_q;
	logic [15:0] idle_q;

	// Tick arithmetic
	time_t             dt_q;
	logic              drift_q;
	logic [PROD_W-1:0] prod_q;
	logic [7:0]        ndt_q;
	logic              div_sat_q;
	logic [23:0]       rem_q;
	logic [22:0]       ds_q;
	logic [QUO_W-1:0]  quo_q;

	// Output register
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;

	time_t       elapsed;
	logic [31:0] dt32;
	logic [27:0] recip;
	logic [15:0] divisor;
	logic [7:0]  slew_step;
	logic [3:0]  face;
	logic [12:0] blink;
	logic signed [13:0] e14;
	logic signed [13:0] period;

	assign elapsed = now_q - last_upd_q;
	assign dt32    = 32'(dt_q);
	assign recip   = 28'(dt_q[14:0]) * RECIP_100;
	assign divisor = (smooth_q == 16'd0) ? 16'd1 : smooth_q;

	// Step of the slew: quotient floored at one, saturated above the range
	always_comb begin
		if (div_sat_q) begin
			slew_step = 8'hFF;
		end else if (quo_q == '0) begin
			slew_step = 8'd1;
		end else begin
			slew_step = quo_q;
		end
	end

	// Face ladder on the current values
	always_comb begin
		if (idle_q > 16'd120) begin
			face = FACE_SLEEPING;
		end else if (idle_q > 16'd45 && cur_e_q < 8'sd12) begin
			face = FACE_SLEEPY;
		end else if (cur_e_q > 8'sd65 && cur_v_q > 8'sd25) begin
			face = FACE_EXCITED;
		end else if (cur_v_q > 8'sd55 && cur_a_q > 8'sd15) begin
			face = FACE_HAPPY;
		end else if (cur_v_q > 8'sd45) begin
			face = FACE_PROUD;
		end else if (cur_v_q < -8'sd45) begin
			face = FACE_SAD;
		end else if (cur_v_q < -8'sd15) begin
			face = FACE_CONFUSED;
		end else if (cur_e_q < 8'sd10 && cur_a_q < -8'sd30) begin
			face = FACE_BORED;
		end else begin
			face = FACE_IDLE;
		end
	end

	// Blink period: base minus 24 times energy, floored
	always_comb begin
		e14 = {{6{cur_e_q[7]}}, cur_e_q};
		period = BLINK_BASE - ((e14 <<< 4) + (e14 <<< 3));
		if (period < BLINK_MIN) begin
			period = BLINK_MIN;
		end
		blink = period[12:0];
	end

	assign sts.mode     = mode_q;
	assign sts.started  = (last_tick_q != '0);
	assign sts.dt_zero  = (dt_q == '0);
	assign sts.out_free = !m_tvalid_q || m_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Config registers and mood state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_v_q <= '0;
			base_a_q <= '0;
			base_e_q <= '0;
			timeout_q <= TIMEOUT_RST;
			smooth_q <= SMOOTH_RST;
			cur_v_q <= '0;
			cur_a_q <= '0;
			cur_e_q <= '0;
			tgt_v_q <= '0;
			tgt_a_q <= '0;
			tgt_e_q <= '0;
			last_tick_q <= '0;
			last_upd_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE_VALENCE: base_v_q <= cfg_data[7:0];
					REG_BASE_AROUSAL: base_a_q <= cfg_data[7:0];
					REG_BASE_ENERGY:  base_e_q <= cfg_data[7:0];
					REG_TIMEOUT_MS:   timeout_q <= cfg_data;
					REG_SMOOTH_MS:    smooth_q <= cfg_data[15:0];
					default: ;
				endcase
			end
			// New targets; the update is stamped with the last tick
			if (cmd.set_apply) begin
				tgt_v_q <= sat100(new_v_q);
				tgt_a_q <= sat100(new_a_q);
				tgt_e_q <= sat100(new_e_q);
				last_upd_q <= last_tick_q;
			end
			// First tick only records the time
			if (cmd.start) begin
				last_tick_q <= now_q;
				last_upd_q <= now_q;
			end
			if (cmd.advance) begin
				last_tick_q <= now_q;
			end
			// Drift targets toward the baselines after the timeout
			if (cmd.pre && drift_q) begin
				tgt_v_q <= move_toward(tgt_v_q, sat100(base_v_q), ndt_q);
				tgt_a_q <= move_toward(tgt_a_q, sat100(base_a_q), ndt_q);
				tgt_e_q <= move_toward(tgt_e_q, sat100(base_e_q), ndt_q);
			end
			// Slew currents toward targets
			if (cmd.slew) begin
				cur_v_q <= move_toward(cur_v_q, tgt_v_q, slew_step);
				cur_a_q <= move_toward(cur_a_q, tgt_a_q, slew_step);
				cur_e_q <= move_toward(cur_e_q, tgt_e_q, slew_step);
			end
		end
	end

	// Item capture and tick arithmetic
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= s_tuser[0];
			now_q <= s_tdata[TIME_BITS-1:0];
			new_v_q <= s_tdata[39:32];
			new_a_q <= s_tdata[47:40];
			new_e_q <= s_tdata[55:48];
			idle_q <= s_tdata[71:56];
		end
		if (cmd.eval) begin
			dt_q <= now_q - last_tick_q;
			drift_q <= (32'(elapsed) > timeout_q);
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(dt32 * SLEW_SCALE);
			ndt_q <= (dt32 >= DRIFT_DT_CAP) ? STEP_CAP : recip[RECIP_SHIFT +: 8];
		end
		if (cmd.pre) begin
			div_sat_q <= (prod_q >= {8'b0, divisor, 8'b0});
			rem_q <= prod_q[23:0];
			ds_q <= {divisor, 7'b0};
			quo_q <= '0;
		end
		// One restoring division step per cycle
		if (cmd.div_step) begin
			if (rem_q >= {1'b0, ds_q}) begin
				rem_q <= rem_q - {1'b0, ds_q};
				quo_q <= {quo_q[QUO_W-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QUO_W-2:0], 1'b0};
			end
			ds_q <= {1'b0, ds_q[22:1]};
		end
		if (cmd.load_out) begin
			m_tdata_q <= {7'b0, blink, face, cur_e_q, cur_a_q, cur_v_q};
		end
	end

	// Output valid: hold until the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

endmodule

// File: design/mood_slew_limiter_face_classifier.sv
// Mood slew limiter with face classifier: one result beat for every input beat.
// A set beat goes from evaluate straight to the output state; a tick beat that moves
// time also passes through multiply, pre, the eight iterations of the slew step
// divider and the slew step. The first tick and a tick at the last tick time skip
// the divider as well. A new beat is taken only once the previous one has reached
// the output register, and is accepted while that result still waits there.
// Depends on mslfc_pkg, mslfc_ctrl and mslfc_dpath.
module mood_slew_limiter_face_classifier import mslfc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata: now_ms[31:0], new_valence[39:32], new_arousal[47:40],
	// new_energy[55:48], idle_sec[71:56]
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_DATA_W-1:0]  s_tdata,
	// s_tuser: mode[0] (0 tick, 1 set targets)
	input  logic [0:0]           s_tuser,
	// m_tdata: cur_valence[7:0], cur_arousal[15:8], cur_energy[23:16],
	// face_class[27:24], blink_period_ms[40:28], zero fill[47:41]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_DATA_W-1:0]  m_tdata,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_DAT_W-1:0] cfg_data
);

	mslfc_cmd_t cmd;
	mslfc_sts_t sts;

	// Config writes are always accepted
	assign cfg_ready = 1'b1;

	mslfc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	mslfc_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

endmodule

// File: design/mslfc_checker.sv
// Port-level checks for the mood slew limiter top level, bound to it below.
// Depends on mslfc_pkg and mood_slew_limiter_face_classifier.
module mslfc_checker import mslfc_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                s_tvalid,
	input logic                s_tready,
	input logic                m_tvalid,
	input logic                m_tready,
	input logic [M_DATA_W-1:0] m_tdata
);

	// Stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result beat dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("result beat changed while stalled");

	// One item at a time: input closes after a beat is taken
	a_in_close: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input still open after accepting a beat");

	// Face class is one of the defined classes
	a_face_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[27:24] <= FACE_IDLE)
		else $error("face class out of range");

	// Blink period stays within its floor and ceiling
	a_blink_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[40:28] >= 13'd1800) && (m_tdata[40:28] <= 13'd6600))
		else $error("blink period out of range");

endmodule

bind mood_slew_limiter_face_classifier mslfc_checker u_mslfc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// File: test/mood_slew_limiter_face_classifier_test.sv
`timescale 1ns / 1ps
// Self-checking bench for mood_slew_limiter_face_classifier: drives tick and set beats,
// predicts every result beat in-bench and compares it field by field.
// Depends on mslfc_pkg and the block's RTL; reads no files.
module mood_slew_limiter_face_classifier_test;
	import mslfc_pkg::*;

	localparam logic MODE_TICK     = 1'b0;
	localparam logic MODE_SET      = 1'b1;
	localparam int   STALL_LIMIT   = 2000;
	localparam int   SETTLE_CYCLES = 16;

	typedef struct packed {
		logic signed [7:0] valence;
		logic signed [7:0] arousal;
		logic signed [7:0] energy;
		logic [3:0]        face;
		logic [12:0]       blink;
	} mood_beat_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	// s_tdata: now_ms, new_valence, new_arousal, new_energy, idle_sec (low bit up)
	logic [S_DATA_W-1:0]  s_tdata;
	// s_tuser: mode
	logic [0:0]           s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	// m_tdata: cur_valence, cur_arousal, cur_energy, face_class, blink_period_ms
	logic [M_DATA_W-1:0]  m_tdata;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;

	mood_slew_limiter_face_classifier dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Expected result beats, oldest first
	mood_beat_t pending_moods[$];
	int mismatches;
	int results_seen;
	int quiet_cycles;
	int send_idle_pct;
	int recv_stall_pct;
	logic [31:0] sim_ms;

	// Mirror of the configuration registers
	int          home_v, home_a, home_e;
	logic [31:0] stale_ms;
	logic [15:0] smooth_div;

	// Mirror of the mood state
	int          mood_v, mood_a, mood_e;
	int          aim_v, aim_a, aim_e;
	logic [31:0] tick_mark, touch_mark;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic int clamp_mood(input int v);
		if (v < int'(MOOD_MIN)) return int'(MOOD_MIN);
		if (v > int'(MOOD_MAX)) return int'(MOOD_MAX);
		return v;
	endfunction

	// Move toward a goal by at most lim, never past it
	function automatic int approach(input int from, input int to, input longint lim);
		longint gap;
		gap = longint'(to) - longint'(from);
		if (gap > lim) return from + int'(lim);
		if (gap < -lim) return from - int'(lim);
		return to;
	endfunction

	// Threshold ladder, first match wins
	function automatic logic [3:0] face_for(input int v, input int a, input int e,
			input logic [15:0] idle);
		if (idle > 16'd120) return FACE_SLEEPING;
		if (idle > 16'd45 && e < 12) return FACE_SLEEPY;
		if (e > 65 && v > 25) return FACE_EXCITED;
		if (v > 55 && a > 15) return FACE_HAPPY;
		if (v > 45) return FACE_PROUD;
		if (v < -45) return FACE_SAD;
		if (v < -15) return FACE_CONFUSED;
		if (e < 10 && a < -30) return FACE_BORED;
		return FACE_IDLE;
	endfunction

	function automatic logic [12:0] blink_for(input int e);
		int p;
		p = 4200 - 24 * e;
		if (p < 1800) p = 1800;
		return p[12:0];
	endfunction

	// Advance time: first tick only starts the clock, zero dt does nothing
	function automatic void advance_clock(input logic [31:0] now);
		logic [31:0] dt;
		logic [31:0] elapsed;
		logic [31:0] span;
		logic [31:0] div;
		logic [31:0] step;
		longint      drift;
		if (tick_mark == 32'd0) begin
			tick_mark = now;
			touch_mark = now;
			return;
		end
		dt = now - tick_mark;
		if (dt == 32'd0) return;
		tick_mark = now;
		elapsed = now - touch_mark;
		// Link stale: pull targets back to the baselines
		if (elapsed > stale_ms) begin
			drift = longint'(dt / 32'd100);
			if (drift > 0) begin
				aim_v = approach(aim_v, clamp_mood(home_v), drift);
				aim_a = approach(aim_a, clamp_mood(home_a), drift);
				aim_e = approach(aim_e, clamp_mood(home_e), drift);
			end
		end
		div = (smooth_div == 16'd0) ? 32'd1 : {16'd0, smooth_div};
		span = dt * 32'd100;
		step = span / div;
		if (step == 32'd0) step = 32'd1;
		mood_v = approach(mood_v, aim_v, longint'(step));
		mood_a = approach(mood_a, aim_a, longint'(step));
		mood_e = approach(mood_e, aim_e, longint'(step));
	endfunction

	function automatic mood_beat_t predict_beat(input logic mode, input logic [31:0] now,
			input mood_t nv, input mood_t na, input mood_t ne, input logic [15:0] idle);
		mood_beat_t r;
		if (mode == MODE_SET) begin
			aim_v = clamp_mood(int'(nv));
			aim_a = clamp_mood(int'(na));
			aim_e = clamp_mood(int'(ne));
			touch_mark = tick_mark;
		end else begin
			advance_clock(now);
		end
		r.valence = mood_v[7:0];
		r.arousal = mood_a[7:0];
		r.energy  = mood_e[7:0];
		r.face    = face_for(mood_v, mood_a, mood_e, idle);
		r.blink   = blink_for(mood_e);
		return r;
	endfunction

	function automatic void note_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [31:0] data);
		case (idx)
			REG_BASE_VALENCE: home_v = int'($signed(data[7:0]));
			REG_BASE_AROUSAL: home_a = int'($signed(data[7:0]));
			REG_BASE_ENERGY:  home_e = int'($signed(data[7:0]));
			REG_TIMEOUT_MS:   stale_ms = data;
			REG_SMOOTH_MS:    smooth_div = data[15:0];
			default: ;
		endcase
	endfunction

	// Random baseline: mostly in range, sometimes any 8-bit value
	function automatic logic [31:0] pick_base();
		int   v;
		logic [7:0] b;
		if ($urandom_range(99) < 80) begin
			v = int'($urandom_range(200)) - 100;
			return 32'(v);
		end
		b = 8'($urandom);
		return {{24{b[7]}}, b};
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $realtime, msg);
		mismatches++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want)
			report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
				results_seen, name, got, want));
	endtask

	// Send one beat, with random idle cycles ahead of it
	task automatic send_beat(input logic mode, input logic [31:0] now, input mood_t nv,
			input mood_t na, input mood_t ne, input logic [15:0] idle);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = mode;
		s_tdata  = {idle, ne, na, nv, now};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		pending_moods.push_back(predict_beat(mode, now, nv, na, ne, idle));
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		note_register(idx, data);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Hold off until every expected result beat has come back
	task automatic settle_block();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_moods.size() != 0) @(posedge clk);
	endtask

	// Not-started state, first tick, repeated time, set saturation, slew and drift
	task automatic test_start_and_repeat();
		send_beat(MODE_TICK, 32'd0, 0, 0, 0, 16'd0);
		send_beat(MODE_TICK, 32'd0, 127, -128, 5, 16'd46);
		send_beat(MODE_SET, 32'hFFFF_FFFF, 127, -128, 100, 16'hFFFF);
		send_beat(MODE_TICK, 32'd1000, -1, -1, -1, 16'd121);
		send_beat(MODE_TICK, 32'd1000, 0, 0, 0, 16'd120);
		send_beat(MODE_TICK, 32'd1040, 0, 0, 0, 16'd120);
		send_beat(MODE_TICK, 32'd1043, 0, 0, 0, 16'd46);
		send_beat(MODE_TICK, 32'd2043, 0, 0, 0, 16'd45);
		send_beat(MODE_SET, 32'd0, -101, 101, -1, 16'd0);
		send_beat(MODE_TICK, 32'd7043, 0, 0, 0, 16'd0);
		send_beat(MODE_TICK, 32'hFFFF_FF00, 0, 0, 0, 16'd0);
		// wrap across zero
		send_beat(MODE_TICK, 32'h0000_0010, 0, 0, 0, 16'd0);
		sim_ms = 32'h0000_0010;
	endtask

	// Out-of-range baselines, zero timeout, zero and largest smoothing
	task automatic test_register_extremes();
		settle_block();
		write_register(REG_BASE_VALENCE, 32'hFFFF_FF80);
		write_register(REG_BASE_AROUSAL, 32'h0000_007F);
		write_register(REG_BASE_ENERGY, 32'hFFFF_FF9C);
		write_register(REG_TIMEOUT_MS, 32'd0);
		write_register(REG_SMOOTH_MS, 32'd0);
		send_beat(MODE_SET, 32'h1234_5678, 0, 0, 0, 16'd30);
		send_beat(MODE_TICK, 32'd166, 0, 0, 0, 16'd30);
		// 100*dt wraps to a tiny step
		send_beat(MODE_TICK, 32'd166 + 32'd42949673, 0, 0, 0, 16'd50);
		// tick at zero drops back to not started
		send_beat(MODE_TICK, 32'd0, 0, 0, 0, 16'd0);
		send_beat(MODE_TICK, 32'd500, 0, 0, 0, 16'd0);
		send_beat(MODE_SET, 32'd0, 55, 16, 66, 16'd0);
		settle_block();
		write_register(REG_TIMEOUT_MS, 32'hFFFF_FFFF);
		write_register(REG_SMOOTH_MS, 32'd65535);
		write_register(REG_BASE_VALENCE, 32'd100);
		send_beat(MODE_TICK, 32'd600, 0, 0, 0, 16'd0);
		send_beat(MODE_TICK, 32'd70600, 0, 0, 0, 16'd0);
		send_beat(MODE_TICK, 32'd3_000_000, 0, 0, 0, 16'd0);
		sim_ms = 32'd3_000_000;
	endtask

	// Random configs and mostly well-formed tick streams with sets mixed in
	task automatic test_random_traffic(input int idle_pct, input int stall_pct,
			input int beats);
		int          pick;
		logic [15:0] idle;
		logic [31:0] gap;
		for (int round = 0; round < 2; round++) begin
			settle_block();
			write_register(REG_BASE_VALENCE, pick_base());
			write_register(REG_BASE_AROUSAL, pick_base());
			write_register(REG_BASE_ENERGY, pick_base());
			case ($urandom_range(4))
				0: write_register(REG_TIMEOUT_MS, 32'd0);
				1: write_register(REG_TIMEOUT_MS, $urandom_range(2000));
				2: write_register(REG_TIMEOUT_MS, 32'(TIMEOUT_RST));
				3: write_register(REG_TIMEOUT_MS, 32'hFFFF_FFFF);
				default: write_register(REG_TIMEOUT_MS, $urandom);
			endcase
			case ($urandom_range(5))
				0: write_register(REG_SMOOTH_MS, 32'd0);
				1: write_register(REG_SMOOTH_MS, 32'd1);
				2: write_register(REG_SMOOTH_MS, 32'd65535);
				default: write_register(REG_SMOOTH_MS, $urandom_range(1000, 1));
			endcase
			send_idle_pct = idle_pct;
			recv_stall_pct = stall_pct;
			for (int n = 0; n < (beats + round) / 2; n++) begin
				pick = $urandom_range(99);
				if (pick < 50) idle = 16'($urandom_range(60));
				else if (pick < 75) idle = 16'($urandom_range(140, 100));
				else idle = 16'($urandom);
				pick = $urandom_range(99);
				if (pick < 25) begin
					send_beat(MODE_SET, $urandom, mood_t'($urandom), mood_t'($urandom),
						mood_t'($urandom), idle);
				end else begin
					// Advance the time cursor: short steps mostly, some jumps and resets
					pick = $urandom_range(99);
					if (pick < 70) gap = $urandom_range(150, 1);
					else if (pick < 78) gap = 32'd0;
					else if (pick < 86) gap = $urandom_range(8000, 200);
					else if (pick < 91) gap = $urandom_range(60000, 8000);
					else gap = $urandom;
					if (pick >= 96) sim_ms = 32'd0;
					else sim_ms = sim_ms + gap;
					send_beat(MODE_TICK, sim_ms, mood_t'($urandom), mood_t'($urandom),
						mood_t'($urandom), idle);
				end
			end
		end
	endtask

	// Receiver stalls at random
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_tready = ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// Compare each result beat with the oldest expectation
	always @(posedge clk) begin
		mood_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_moods.size() == 0) begin
				report_mismatch($sformatf("result %0d arrived with nothing expected",
					results_seen));
			end else begin
				want = pending_moods.pop_front();
				check_field("cur_valence", {8'd0, m_tdata[7:0]}, {8'd0, want.valence});
				check_field("cur_arousal", {8'd0, m_tdata[15:8]}, {8'd0, want.arousal});
				check_field("cur_energy", {8'd0, m_tdata[23:16]}, {8'd0, want.energy});
				check_field("face_class", {12'd0, m_tdata[27:24]}, {12'd0, want.face});
				check_field("blink_period_ms", {3'd0, m_tdata[40:28]}, {3'd0, want.blink});
			end
			results_seen++;
		end
	end

	// End the run when no beat moves for too long
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("mood_slew_limiter_face_classifier_test NOT OK");
				$finish;
			end
		end
	end

	initial begin
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		mismatches = 0;
		results_seen = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		sim_ms = 32'd0;
		home_v = 0;
		home_a = 0;
		home_e = 0;
		stale_ms = 32'(TIMEOUT_RST);
		smooth_div = SMOOTH_RST;
		mood_v = 0;
		mood_a = 0;
		mood_e = 0;
		aim_v = 0;
		aim_a = 0;
		aim_e = 0;
		tick_mark = 32'd0;
		touch_mark = 32'd0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 12;
		recv_stall_pct = 45;
		test_start_and_repeat();
		test_register_extremes();
		test_random_traffic(12, 45, 283);
		test_random_traffic(45, 12, 283);
		test_random_traffic(0, 0, 284);

		settle_block();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_moods.size() == 0) begin
			$display("mood_slew_limiter_face_classifier_test OK");
		end else begin
			$display("mood_slew_limiter_face_classifier_test NOT OK");
		end
		$finish;
	end

endmodule

// File: sim.f
design/mslfc_pkg.sv
design/mslfc_ctrl.sv
design/mslfc_dpath.sv
design/mood_slew_limiter_face_classifier.sv
design/mslfc_checker.sv
test/mood_slew_limiter_face_classifier_test.sv
